[rtl/mbrq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrq_pkg
// Shared constants, types and helpers for the buffer rotation queue.
// ----------------------------------------------------------------------------
package mbrq_pkg;

   localparam int QUEUE_DEPTH  = 8;
   localparam int BUFFER_COUNT = 6;

   localparam int IDX_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int BUF_W   = 3;
   localparam int SLOT_W  = 8;
   localparam int BYTES_W = 24;
   localparam int TICK_W  = 32;
   localparam int RATE_W  = 16;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 3;
   localparam int STEP_W  = $clog2(BYTES_W + 1);

   localparam logic CMD_TRANSFER = 1'b0;
   localparam logic CMD_DEQUEUE  = 1'b1;

   // register select is address bit 2
   localparam logic REG_TRANSFERS = 1'b0;
   localparam logic REG_BYTES     = 1'b1;

   localparam logic [SLOT_W-1:0]  TRANSFERS_RESET = SLOT_W'(4);
   localparam logic [BYTES_W-1:0] BYTES_RESET     = BYTES_W'(32768);
   localparam logic [RATE_W-1:0]  RATE_MAX        = '1;
   localparam logic [BUF_W-1:0]   BUFFER_FIRST    = BUF_W'(1);
   localparam logic [BUF_W-1:0]   BUFFER_LAST     = BUF_W'(BUFFER_COUNT);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIVIDE,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic load;
   } ctrl_type;

   typedef struct packed {
      logic push;
      logic div_done;
      logic out_free;
   } stat_type;

   function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] nxt;
      nxt = (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
      return nxt;
   endfunction

endpackage

[rtl/mbrq_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrq_div
// Restoring divider, one quotient bit per cycle, for the rate measurement.
// ----------------------------------------------------------------------------
module mbrq_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [mbrq_pkg::BYTES_W-1:0] dividend,
   input  logic [mbrq_pkg::TICK_W-1:0]  divisor,
   output logic                         done,
   output logic [mbrq_pkg::BYTES_W-1:0] quotient
);
   import mbrq_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [BYTES_W-1:0]  num_ff, num_in;
   logic [TICK_W-1:0]   rem_ff, rem_in;
   logic [TICK_W-1:0]   den_ff, den_in;
   logic [TICK_W:0]     trial;
   logic [TICK_W:0]     diff;

   always_comb begin
      trial   = {rem_ff, num_ff[BYTES_W-1]};
      diff    = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(BYTES_W);
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         // zero divisor gives all ones, which later saturates
         if (!diff[TICK_W]) begin
            rem_in = diff[TICK_W-1:0];
            num_in = {num_ff[BYTES_W-2:0], 1'b1};
         end else begin
            rem_in = trial[TICK_W-1:0];
            num_in = {num_ff[BYTES_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

[rtl/mbrq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrq_datapath
// Settings, fill counters, ring fifo, rate measurement and result register.
// ----------------------------------------------------------------------------
module mbrq_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  mbrq_pkg::ctrl_type           ctrl,
   output mbrq_pkg::stat_type           stat,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [mbrq_pkg::ADDR_W-1:0]  paddr,
   input  logic [mbrq_pkg::DATA_W-1:0]  pwdata,
   output logic [mbrq_pkg::DATA_W-1:0]  prdata,
   input  logic                         req_command,
   input  logic [mbrq_pkg::TICK_W-1:0]  req_tick_time,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [mbrq_pkg::BUF_W-1:0]   rsp_active_buffer,
   output logic [mbrq_pkg::SLOT_W-1:0]  rsp_fill_slot,
   output logic [mbrq_pkg::BUF_W-1:0]   rsp_completed_buffer,
   output logic                         rsp_push_dropped,
   output logic [mbrq_pkg::BUF_W-1:0]   rsp_popped_buffer,
   output logic [mbrq_pkg::BUF_W-1:0]   rsp_head_buffer,
   output logic [3:0]                   rsp_queue_count,
   output logic [mbrq_pkg::RATE_W-1:0]  rsp_data_rate
);
   import mbrq_pkg::*;

   logic [SLOT_W-1:0]  tps_ff, tps_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic               cmd_ff;
   logic [TICK_W-1:0]  tick_ff;
   logic [BUF_W-1:0]   cur_ff, cur_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [BUF_W-1:0]   store_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TICK_W-1:0]  last_ff, last_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [BUF_W-1:0]   completed_ff, completed_in;
   logic               dropped_ff, dropped_in;
   logic [BUF_W-1:0]   popped_ff, popped_in;
   logic               out_valid_ff, out_valid_in;
   logic [BUF_W-1:0]   out_active_ff, out_completed_ff, out_popped_ff, out_head_ff;
   logic [SLOT_W-1:0]  out_slot_ff;
   logic               out_dropped_ff;
   logic [CNT_W-1:0]   out_count_ff;
   logic [RATE_W-1:0]  out_rate_ff;

   logic [SLOT_W-1:0]  slot_inc;
   logic               push;
   logic               full;
   logic               store_wr;
   logic [IDX_W-1:0]   tail_next;
   logic [BUF_W-1:0]   head_val;
   logic               csr_wr;
   logic               div_done;
   logic [BYTES_W-1:0] div_q;

   assign slot_inc  = slot_ff + 1'b1;
   assign push      = (cmd_ff == CMD_TRANSFER) && (slot_inc == tps_ff);
   assign full      = (count_ff >= CNT_W'(QUEUE_DEPTH));
   assign tail_next = next_index(tail_ff);
   assign store_wr  = ctrl.exec && push && !full;
   assign head_val  = (count_ff != '0) ? store_ff[head_ff] : '0;
   assign csr_wr    = psel && penable && pwrite;

   assign stat.push     = push;
   assign stat.div_done = div_done;
   assign stat.out_free = !out_valid_ff || !rsp_stall;

   mbrq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.exec && push),
      .dividend (bytes_ff),
      .divisor  (tick_ff - last_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      tps_in       = tps_ff;
      bytes_in     = bytes_ff;
      cur_in       = cur_ff;
      slot_in      = slot_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      rate_in      = rate_ff;
      completed_in = completed_ff;
      dropped_in   = dropped_ff;
      popped_in    = popped_ff;
      out_valid_in = out_valid_ff && rsp_stall;

      if (csr_wr) begin
         if (paddr[2] == REG_TRANSFERS) begin
            tps_in = pwdata[SLOT_W-1:0];
         end else begin
            bytes_in = pwdata[BYTES_W-1:0];
         end
      end

      if (ctrl.exec) begin
         completed_in = '0;
         dropped_in   = 1'b0;
         popped_in    = '0;
         if (cmd_ff == CMD_TRANSFER) begin
            slot_in = slot_inc;
            if (push) begin
               completed_in = cur_ff;
               slot_in      = '0;
               last_in      = tick_ff;
               if ((cur_ff >= BUFFER_LAST) || (cur_ff == '0)) begin
                  cur_in = BUFFER_FIRST;
               end else begin
                  cur_in = cur_ff + 1'b1;
               end
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  tail_in  = tail_next;
                  count_in = count_ff + 1'b1;
               end
            end
         end else if (count_ff != '0) begin
            popped_in = store_ff[head_ff];
            head_in   = next_index(head_ff);
            count_in  = count_ff - 1'b1;
         end
      end

      if (div_done) begin
         rate_in = (div_q > BYTES_W'(RATE_MAX)) ? RATE_MAX : div_q[RATE_W-1:0];
      end

      if (ctrl.load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff       <= TRANSFERS_RESET;
         bytes_ff     <= BYTES_RESET;
         cur_ff       <= BUFFER_FIRST;
         slot_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= IDX_W'(QUEUE_DEPTH - 1);
         count_ff     <= '0;
         last_ff      <= '0;
         rate_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         tps_ff       <= tps_in;
         bytes_ff     <= bytes_in;
         cur_ff       <= cur_in;
         slot_ff      <= slot_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         rate_ff      <= rate_in;
         out_valid_ff <= out_valid_in;
      end
      completed_ff <= completed_in;
      dropped_ff   <= dropped_in;
      popped_ff    <= popped_in;
   end

   // request capture
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff  <= req_command;
         tick_ff <= req_tick_time;
      end
   end

   // fifo store
   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_ff[tail_next] <= cur_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         out_active_ff    <= cur_ff;
         out_slot_ff      <= slot_ff;
         out_completed_ff <= completed_ff;
         out_dropped_ff   <= dropped_ff;
         out_popped_ff    <= popped_ff;
         out_head_ff      <= head_val;
         out_count_ff     <= count_ff;
         out_rate_ff      <= rate_ff;
      end
   end

   assign prdata = (paddr[2] == REG_BYTES) ? DATA_W'(bytes_ff) : DATA_W'(tps_ff);

   assign rsp_valid            = out_valid_ff;
   assign rsp_active_buffer    = out_active_ff;
   assign rsp_fill_slot        = out_slot_ff;
   assign rsp_completed_buffer = out_completed_ff;
   assign rsp_push_dropped     = out_dropped_ff;
   assign rsp_popped_buffer    = out_popped_ff;
   assign rsp_head_buffer      = out_head_ff;
   assign rsp_queue_count      = 4'(out_count_ff);
   assign rsp_data_rate        = out_rate_ff;

endmodule

[rtl/mbrq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrq_ctrl
// Sequencer: capture, execute, wait for the rate divider, write the result.
// ----------------------------------------------------------------------------
module mbrq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output mbrq_pkg::ctrl_type ctrl,
   input  mbrq_pkg::stat_type stat
);
   import mbrq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ctrl.capture = 1'b0;
      ctrl.exec    = 1'b0;
      ctrl.load    = 1'b0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl.capture = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctrl.exec = 1'b1;
            state_in  = stat.push ? ST_DIVIDE : ST_WRITE;
         end
         ST_DIVIDE: begin
            if (stat.div_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (stat.out_free) begin
               ctrl.load = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/multi_buffer_rotation_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_buffer_rotation_queue
// Six-buffer fill rotation with a ring fifo of finished buffers and a
// bytes-per-tick rate measurement on every buffer switch.
//
// Request channel: req_valid / req_stall with req_command (0 transfer done,
// 1 dequeue) and req_tick_time. One response per request on rsp_valid /
// rsp_stall, carrying fill position, finished and popped buffers, fifo head
// and count, and the latest rate.
// Sequence: a taken request is captured, then executed; on a buffer switch
// the block waits for the 24-step restoring divider that computes the rate,
// and then loads the response register. One request is in flight at a
// time: no new request is taken until the current response is loaded.
// The response register sits between the channels: a new request is taken
// while an earlier response is still stalled, and the block holds in its
// last step until the response register frees.
// Reset (synchronous) restores both settings, sets buffer 1, slot 0, an empty
// fifo and a zero rate. Settings are written on the APB-style port.
// ----------------------------------------------------------------------------
module multi_buffer_rotation_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [mbrq_pkg::ADDR_W-1:0]  paddr,
   input  logic [mbrq_pkg::DATA_W-1:0]  pwdata,
   output logic [mbrq_pkg::DATA_W-1:0]  prdata,
   output logic                         pready,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_command,
   input  logic [mbrq_pkg::TICK_W-1:0]  req_tick_time,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [mbrq_pkg::BUF_W-1:0]   rsp_active_buffer,
   output logic [mbrq_pkg::SLOT_W-1:0]  rsp_fill_slot,
   output logic [mbrq_pkg::BUF_W-1:0]   rsp_completed_buffer,
   output logic                         rsp_push_dropped,
   output logic [mbrq_pkg::BUF_W-1:0]   rsp_popped_buffer,
   output logic [mbrq_pkg::BUF_W-1:0]   rsp_head_buffer,
   output logic [3:0]                   rsp_queue_count,
   output logic [mbrq_pkg::RATE_W-1:0]  rsp_data_rate
);
   import mbrq_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   assign pready = 1'b1;

   mbrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .ctrl      (ctrl),
      .stat      (stat)
   );

   mbrq_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .ctrl                 (ctrl),
      .stat                 (stat),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .req_command          (req_command),
      .req_tick_time        (req_tick_time),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_active_buffer    (rsp_active_buffer),
      .rsp_fill_slot        (rsp_fill_slot),
      .rsp_completed_buffer (rsp_completed_buffer),
      .rsp_push_dropped     (rsp_push_dropped),
      .rsp_popped_buffer    (rsp_popped_buffer),
      .rsp_head_buffer      (rsp_head_buffer),
      .rsp_queue_count      (rsp_queue_count),
      .rsp_data_rate        (rsp_data_rate)
   );

endmodule
